// ===== hw/rtl/jaan_pkg.sv =====
`default_nettype none
package jaan_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int SAMPLES_PER_READ = 5;
	localparam int SAMPLE_FIELDS = 5;
	localparam int N_USED = (SAMPLES_PER_READ > SAMPLE_FIELDS) ? SAMPLE_FIELDS :
		((SAMPLES_PER_READ < 1) ? 1 : SAMPLES_PER_READ);

	localparam int CENTER_W = 12;
	localparam int SPAN_W = 11;
	localparam int DZ_W = 14;
	localparam int CFG_W = 14;

	// center + span takes one bit over the center
	localparam int ACC_B = (SAMPLE_BITS > CENTER_W + 1) ? SAMPLE_BITS : CENTER_W + 1;
	localparam int SUM_W = ACC_B + $clog2(N_USED);
	localparam int EXT_W = SUM_W + 2;
	localparam int CNT_W = (N_USED > 1) ? $clog2(N_USED) : 1;

	localparam int FULL_SCALE = 10000;
	localparam int Q_W = 14;
	localparam int POS_W = Q_W + 1;
	localparam int PROD_W = SUM_W + Q_W;
	localparam int DCNT_W = $clog2(Q_W);

	localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(2048);
	localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(1229);
	localparam logic [DZ_W-1:0] DZ_RST = DZ_W'(1000);

	typedef enum logic [1:0] {
		CFG_CENTER_H = 2'd0,
		CFG_CENTER_V = 2'd1,
		CFG_SPAN = 2'd2,
		CFG_DEAD_ZONE = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_EXT,
		ST_RNG,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic axis;
		logic [SAMPLE_BITS-1:0] sample_0;
		logic [SAMPLE_BITS-1:0] sample_1;
		logic [SAMPLE_BITS-1:0] sample_2;
		logic [SAMPLE_BITS-1:0] sample_3;
		logic [SAMPLE_BITS-1:0] sample_4;
	} req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic axis_echo;
	} rsp_t;

	// N * (center -/+ span)
	function automatic logic signed [EXT_W-1:0] seed(
		input logic [CENTER_W-1:0] c,
		input logic [SPAN_W-1:0] s,
		input logic up
	);
		logic signed [EXT_W-1:0] cx;
		logic signed [EXT_W-1:0] sx;
		logic signed [EXT_W-1:0] d;
		cx = $signed(EXT_W'(c));
		sx = $signed(EXT_W'(s));
		d = up ? (cx + sx) : (cx - sx);
		return EXT_W'(d * N_USED);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/jaan_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle: quot = (num * FULL_SCALE) / den.
// Requires num <= den; den == 0 gives 0.
module jaan_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [jaan_pkg::SUM_W-1:0] num,
	input wire logic [jaan_pkg::SUM_W-1:0] den,
	output logic done,
	output logic [jaan_pkg::Q_W-1:0] quot
);

	logic busy_q;
	logic done_q;
	logic [jaan_pkg::DCNT_W-1:0] cnt_q;
	logic [jaan_pkg::SUM_W-1:0] rem_q;
	logic [jaan_pkg::Q_W-1:0] dd_q;
	logic [jaan_pkg::Q_W-1:0] q_q;
	logic [jaan_pkg::SUM_W-1:0] den_q;
	logic zero_q;

	logic [jaan_pkg::PROD_W-1:0] prod;
	logic [jaan_pkg::SUM_W+1:0] trial;
	logic ge;

	assign prod = jaan_pkg::PROD_W'(num) * jaan_pkg::PROD_W'(jaan_pkg::FULL_SCALE);
	assign trial = {1'b0, rem_q, dd_q[jaan_pkg::Q_W-1]} - {2'b00, den_q};
	assign ge = ~trial[jaan_pkg::SUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == jaan_pkg::DCNT_W'(jaan_pkg::Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[jaan_pkg::PROD_W-1:jaan_pkg::Q_W];
			dd_q <= prod[jaan_pkg::Q_W-1:0];
			den_q <= den;
			zero_q <= (den == '0);
			q_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= trial[jaan_pkg::SUM_W-1:0];
			end else begin
				rem_q <= {rem_q[jaan_pkg::SUM_W-2:0], dd_q[jaan_pkg::Q_W-1]};
			end
			dd_q <= {dd_q[jaan_pkg::Q_W-2:0], 1'b0};
			q_q <= {q_q[jaan_pkg::Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 : q_q;

endmodule
`default_nettype wire

// ===== hw/rtl/joystick_axis_autocal_normalizer.sv =====
`default_nettype none
// channel  signals                                  beat
// req      req_valid/req_ready/req                  one axis read (axis, five samples)
// rsp      rsp_valid/rsp_ready/rsp                  position, axis_echo
// cfg      cfg_valid/cfg_ready/cfg_index/cfg_data   one register write
//
// Each read goes through serial sample summing, extreme tracking and travel, the
// bit-serial divider, and dead zone and handoff before the next read is taken.
// Reset loads register defaults and seeds extremes. A center or span write
// re-seeds in the next cycle, req_ready low meanwhile. A held rsp beat does not
// block the next req; a finished read waits only if rsp still holds a beat.
module joystick_axis_autocal_normalizer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire jaan_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output jaan_pkg::rsp_t rsp,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire jaan_pkg::cfg_idx_t cfg_index,
	input wire logic [jaan_pkg::CFG_W-1:0] cfg_data
);

	jaan_pkg::state_t st_q, st_d;

	logic [jaan_pkg::CENTER_W-1:0] ctr_h_q;
	logic [jaan_pkg::CENTER_W-1:0] ctr_v_q;
	logic [jaan_pkg::SPAN_W-1:0] span_q;
	logic [jaan_pkg::DZ_W-1:0] dz_q;
	logic reseed_q;
	logic signed [jaan_pkg::EXT_W-1:0] low_q [2];
	logic signed [jaan_pkg::EXT_W-1:0] high_q [2];

	logic [jaan_pkg::SAMPLE_BITS-1:0] samp_q [jaan_pkg::SAMPLE_FIELDS];
	logic [jaan_pkg::SUM_W-1:0] acc_q;
	logic [jaan_pkg::CNT_W-1:0] cnt_q;
	logic axis_q;
	logic neg_q;
	logic [jaan_pkg::SUM_W-1:0] m_q;
	logic rsp_valid_q;
	jaan_pkg::rsp_t rsp_q;

	logic div_start;
	logic div_done;
	logic [jaan_pkg::Q_W-1:0] div_q;
	logic rsp_load;

	logic [jaan_pkg::SUM_W-1:0] ctr_sel;
	logic signed [jaan_pkg::EXT_W-1:0] sum_x;
	logic signed [jaan_pkg::EXT_W-1:0] ctr_x;
	logic signed [jaan_pkg::EXT_W-1:0] hi_new;
	logic signed [jaan_pkg::EXT_W-1:0] lo_new;
	logic neg_c;
	logic [jaan_pkg::SUM_W-1:0] m_c;
	logic signed [jaan_pkg::EXT_W-1:0] rng_x;
	logic [jaan_pkg::Q_W-1:0] mag_dz;
	logic [jaan_pkg::POS_W-1:0] pos_c;
	logic cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid & cfg_ready;

	assign ctr_sel = jaan_pkg::SUM_W'((axis_q ? ctr_v_q : ctr_h_q) * jaan_pkg::N_USED);
	assign sum_x = $signed(jaan_pkg::EXT_W'(acc_q));
	assign ctr_x = $signed(jaan_pkg::EXT_W'(ctr_sel));
	assign hi_new = (sum_x > high_q[axis_q]) ? sum_x : high_q[axis_q];
	assign lo_new = (sum_x < low_q[axis_q]) ? sum_x : low_q[axis_q];
	assign neg_c = acc_q < ctr_sel;
	assign m_c = neg_c ? (ctr_sel - acc_q) : (acc_q - ctr_sel);
	assign rng_x = neg_q ? (ctr_x - low_q[axis_q]) : (high_q[axis_q] - ctr_x);
	assign mag_dz = (div_q < dz_q) ? '0 : div_q;
	assign pos_c = neg_q ? (jaan_pkg::POS_W'(0) - {1'b0, mag_dz}) : {1'b0, mag_dz};

	jaan_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(m_q),
		.den(rng_x[jaan_pkg::SUM_W-1:0]),
		.done(div_done),
		.quot(div_q)
	);

	always_comb begin
		st_d = st_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		rsp_load = 1'b0;
		unique case (st_q)
			jaan_pkg::ST_IDLE: begin
				req_ready = ~reseed_q;
				if (req_valid && !reseed_q) st_d = jaan_pkg::ST_SUM;
			end
			jaan_pkg::ST_SUM: begin
				if (cnt_q == jaan_pkg::CNT_W'(jaan_pkg::N_USED - 1)) st_d = jaan_pkg::ST_EXT;
			end
			jaan_pkg::ST_EXT: st_d = jaan_pkg::ST_RNG;
			jaan_pkg::ST_RNG: begin
				div_start = 1'b1;
				st_d = jaan_pkg::ST_DIV;
			end
			jaan_pkg::ST_DIV: begin
				if (div_done) st_d = jaan_pkg::ST_FIN;
			end
			jaan_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					st_d = jaan_pkg::ST_IDLE;
				end
			end
			default: st_d = jaan_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= jaan_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// registers and tracked extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_h_q <= jaan_pkg::CENTER_RST;
			ctr_v_q <= jaan_pkg::CENTER_RST;
			span_q <= jaan_pkg::SPAN_RST;
			dz_q <= jaan_pkg::DZ_RST;
			reseed_q <= 1'b0;
			low_q[0] <= jaan_pkg::seed(jaan_pkg::CENTER_RST, jaan_pkg::SPAN_RST, 1'b0);
			low_q[1] <= jaan_pkg::seed(jaan_pkg::CENTER_RST, jaan_pkg::SPAN_RST, 1'b0);
			high_q[0] <= jaan_pkg::seed(jaan_pkg::CENTER_RST, jaan_pkg::SPAN_RST, 1'b1);
			high_q[1] <= jaan_pkg::seed(jaan_pkg::CENTER_RST, jaan_pkg::SPAN_RST, 1'b1);
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					jaan_pkg::CFG_CENTER_H: begin
						ctr_h_q <= cfg_data[jaan_pkg::CENTER_W-1:0];
						reseed_q <= 1'b1;
					end
					jaan_pkg::CFG_CENTER_V: begin
						ctr_v_q <= cfg_data[jaan_pkg::CENTER_W-1:0];
						reseed_q <= 1'b1;
					end
					jaan_pkg::CFG_SPAN: begin
						span_q <= cfg_data[jaan_pkg::SPAN_W-1:0];
						reseed_q <= 1'b1;
					end
					jaan_pkg::CFG_DEAD_ZONE: dz_q <= cfg_data[jaan_pkg::DZ_W-1:0];
				endcase
			end else if (reseed_q) begin
				reseed_q <= 1'b0;
			end
			if (reseed_q) begin
				low_q[0] <= jaan_pkg::seed(ctr_h_q, span_q, 1'b0);
				high_q[0] <= jaan_pkg::seed(ctr_h_q, span_q, 1'b1);
				low_q[1] <= jaan_pkg::seed(ctr_v_q, span_q, 1'b0);
				high_q[1] <= jaan_pkg::seed(ctr_v_q, span_q, 1'b1);
			end else if (st_q == jaan_pkg::ST_EXT) begin
				low_q[axis_q] <= lo_new;
				high_q[axis_q] <= hi_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			jaan_pkg::ST_IDLE: begin
				samp_q[0] <= req.sample_0;
				samp_q[1] <= req.sample_1;
				samp_q[2] <= req.sample_2;
				samp_q[3] <= req.sample_3;
				samp_q[4] <= req.sample_4;
				axis_q <= req.axis;
				acc_q <= '0;
				cnt_q <= '0;
			end
			jaan_pkg::ST_SUM: begin
				acc_q <= acc_q + jaan_pkg::SUM_W'(samp_q[0]);
				for (int i = 0; i < jaan_pkg::SAMPLE_FIELDS - 1; i++) begin
					samp_q[i] <= samp_q[i+1];
				end
				cnt_q <= cnt_q + 1'b1;
			end
			jaan_pkg::ST_EXT: begin
				neg_q <= neg_c;
				m_q <= m_c;
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q.position <= $signed(pos_c);
			rsp_q.axis_echo <= axis_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
`default_nettype wire
